// ===== src/ts_packet_classifier_assert.svh =====
// assertion macros for the transport stream packet classifier
// no dependencies; ASSERT_OFF removes every check
`ifndef TS_PACKET_CLASSIFIER_ASSERT_SVH
`define TS_PACKET_CLASSIFIER_ASSERT_SVH
`ifndef ASSERT_OFF
`define TSPC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tspc assertion failed");
`define TSPC_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("tspc forbidden condition");
`else
`define TSPC_ASSERT(label, clk, rst, prop)
`define TSPC_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== src/tspc_pkg.sv =====
// shared types, codes and constants of the transport stream packet classifier
// no dependencies
package tspc_pkg;
   localparam int PACKET_BYTES_DEF = 188;
   localparam int COUNT_BITS_DEF   = 32;
   localparam int PID_SLOTS        = 8192;
   localparam int PID_BITS         = 13;
   localparam int HDR_KEEP         = 28;
   localparam int HDR_IDX_BITS     = 5;

   localparam logic [7:0]  SYNC_BYTE      = 8'h47;
   localparam logic [12:0] NULL_PID       = 13'h1FFF;
   localparam logic [12:0] PAT_PID        = 13'h0000;
   localparam logic [12:0] CAT_PID        = 13'h0001;
   localparam logic [12:0] CONTENT_LO     = 13'h0020;
   localparam logic [12:0] CONTENT_HI     = 13'h1FFE;
   localparam logic [12:0] MARKER_PID_RST = 13'h1FF0;
   localparam logic [7:0]  MARKER_TID_RST = 8'hBF;
   localparam logic [11:0] MARKER_LEN_RST = 12'd20;
   localparam logic [7:0]  PCR_MIN_AF_LEN = 8'd7;
   localparam logic [41:0] PCR_MULT       = 42'd300;

   localparam logic [1:0] REG_MARKER_PID = 2'd0;
   localparam logic [1:0] REG_MARKER_TID = 2'd1;
   localparam logic [1:0] REG_MARKER_LEN = 2'd2;

   localparam logic [1:0] ACT_BYTE     = 2'd0;
   localparam logic [1:0] ACT_PID_READ = 2'd1;
   localparam logic [1:0] ACT_SUM_READ = 2'd2;
   localparam logic [1:0] ACT_UNUSED   = 2'd3;

   localparam logic [12:0] SUM_TOTAL   = 13'd0;
   localparam logic [12:0] SUM_SYNC    = 13'd1;
   localparam logic [12:0] SUM_MARKER  = 13'd2;
   localparam logic [12:0] SUM_NULL    = 13'd3;
   localparam logic [12:0] SUM_CONTENT = 13'd4;
   localparam logic [12:0] SUM_PCR     = 13'd5;

   typedef enum logic [2:0] {
      CLS_SYNC_ERR = 3'd0,
      CLS_NULL     = 3'd1,
      CLS_MARKER   = 3'd2,
      CLS_PAT      = 3'd3,
      CLS_CAT      = 3'd4,
      CLS_CONTENT  = 3'd5,
      CLS_RESERVED = 3'd6,
      CLS_COUNTER  = 3'd7
   } class_type;

   typedef enum logic [1:0] {
      MST_NONE    = 2'd0,
      MST_VALID   = 2'd1,
      MST_INVALID = 2'd2
   } marker_status_type;

   typedef enum logic [1:0] {
      KIND_REPORT   = 2'd0,
      KIND_PID_READ = 2'd1,
      KIND_SUM_READ = 2'd2
   } kind_type;

   typedef struct packed {
      class_type         packet_class;
      logic [12:0]       packet_pid;
      logic              pcr_found;
      logic [41:0]       pcr_value;
      marker_status_type marker_status;
      logic [31:0]       marker_sequence;
      logic [15:0]       marker_non_null;
      logic [15:0]       marker_null;
      logic [15:0]       rtp_start_seq;
      logic [15:0]       rtp_next_seq;
      logic [31:0]       stream_ssrc;
      logic [31:0]       counter_value;
   } rsp_type;

   typedef struct packed {
      logic cnt_we;
      logic total;
      logic sync_err;
      logic marker;
      logic null_pkt;
      logic content;
      logic pcr;
   } upd_type;
endpackage

// ===== src/tspc_ram.sv =====
// generic simple dual port ram, registered read, read-first on collision
// no dependencies
module tspc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== src/tspc_report.sv =====
// report decode: classifies a captured header or answers a counter read, and builds one result beat
// depends on tspc_pkg
module tspc_report #(
   parameter int COUNT_BITS = tspc_pkg::COUNT_BITS_DEF
) (
   input  tspc_pkg::kind_type  kind,
   input  logic [12:0]         index,
   input  logic [7:0]          hdr [tspc_pkg::HDR_KEEP],
   input  logic [12:0]         mark_pid,
   input  logic [7:0]          marker_tid,
   input  logic [11:0]         marker_len,
   input  logic [COUNT_BITS-1:0] pid_count,
   input  logic [COUNT_BITS-1:0] sum_value,
   output tspc_pkg::rsp_type   rsp,
   output tspc_pkg::upd_type   upd
);
   logic [12:0] pid;
   logic [11:0] slen;
   logic [32:0] pcr_hi;
   logic [8:0]  pcr_ext;

   assign pid      = {hdr[1][4:0], hdr[2]};
   assign slen     = {hdr[6][3:0], hdr[7]};
   assign pcr_hi   = {hdr[6], hdr[7], hdr[8], hdr[9], hdr[10][7]};
   assign pcr_ext  = {hdr[10][0], hdr[11]};

   always_comb begin
      rsp = '0;
      upd = '0;
      case (kind)
         tspc_pkg::KIND_PID_READ: begin
            rsp.packet_class  = tspc_pkg::CLS_COUNTER;
            rsp.packet_pid    = index;
            rsp.counter_value = 32'(pid_count);
         end
         tspc_pkg::KIND_SUM_READ: begin
            rsp.packet_class  = tspc_pkg::CLS_COUNTER;
            rsp.packet_pid    = index;
            rsp.counter_value = 32'(sum_value);
         end
         tspc_pkg::KIND_REPORT: begin
            upd.total = 1'b1;
            if (hdr[0] != tspc_pkg::SYNC_BYTE) begin
               upd.sync_err     = 1'b1;
               rsp.packet_class = tspc_pkg::CLS_SYNC_ERR;
            end else begin
               upd.cnt_we     = 1'b1;
               rsp.packet_pid = pid;
               if (pid == tspc_pkg::NULL_PID) begin
                  upd.null_pkt     = 1'b1;
                  rsp.packet_class = tspc_pkg::CLS_NULL;
               end else if (pid == mark_pid) begin
                  upd.marker       = 1'b1;
                  rsp.packet_class = tspc_pkg::CLS_MARKER;
                  if (hdr[1][6] && hdr[4] == 8'd0) begin
                     if (hdr[5] == marker_tid && slen == marker_len) begin
                        rsp.marker_status   = tspc_pkg::MST_VALID;
                        rsp.marker_sequence = {hdr[8], hdr[9], hdr[10], hdr[11]};
                        rsp.marker_non_null = {hdr[12], hdr[13]};
                        rsp.marker_null     = {hdr[14], hdr[15]};
                        rsp.rtp_start_seq   = {hdr[18], hdr[19]};
                        rsp.rtp_next_seq    = {hdr[22], hdr[23]};
                        rsp.stream_ssrc     = {hdr[24], hdr[25], hdr[26], hdr[27]};
                     end else begin
                        rsp.marker_status = tspc_pkg::MST_INVALID;
                     end
                  end
               end else if (pid == tspc_pkg::PAT_PID) begin
                  rsp.packet_class = tspc_pkg::CLS_PAT;
               end else if (pid == tspc_pkg::CAT_PID) begin
                  rsp.packet_class = tspc_pkg::CLS_CAT;
               end else begin
                  if (hdr[3][5] && hdr[4] >= tspc_pkg::PCR_MIN_AF_LEN && hdr[5][4]) begin
                     upd.pcr       = 1'b1;
                     rsp.pcr_found = 1'b1;
                     rsp.pcr_value = 42'(pcr_hi) * tspc_pkg::PCR_MULT + 42'(pcr_ext);
                  end
                  if (pid inside {[tspc_pkg::CONTENT_LO:tspc_pkg::CONTENT_HI]}) begin
                     upd.content      = 1'b1;
                     rsp.packet_class = tspc_pkg::CLS_CONTENT;
                  end else begin
                     rsp.packet_class = tspc_pkg::CLS_RESERVED;
                  end
               end
            end
         end
         default: begin
            rsp = '0;
            upd = '0;
         end
      endcase
   end
endmodule

// ===== src/ts_packet_classifier.sv =====
// transport stream packet classifier top: capture, per-pid count ram, output queue
// depends on tspc_pkg, tspc_ram, tspc_report and ts_packet_classifier_assert.svh
// throughput: one beat per cycle while req_ready is high; results pass the s1 stage register into the output queue
// per-pid counts are read at accept and written back from the s1 stage in the next cycle, with forwarding
// reset: synchronous; a clearing pass zeroes every slot of the count ram while req_ready is low
// configuration writes are taken during the clearing pass
`include "ts_packet_classifier_assert.svh"
module ts_packet_classifier #(
   parameter int PACKET_BYTES = tspc_pkg::PACKET_BYTES_DEF,
   parameter int COUNT_BITS   = tspc_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_byte_value,
   input  logic        req_packet_start,
   input  logic [12:0] req_counter_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_packet_class,
   output logic [12:0] rsp_packet_pid,
   output logic        rsp_pcr_found,
   output logic [41:0] rsp_pcr_value,
   output logic [1:0]  rsp_marker_status,
   output logic [31:0] rsp_marker_sequence,
   output logic [15:0] rsp_marker_non_null,
   output logic [15:0] rsp_marker_null,
   output logic [15:0] rsp_rtp_start_seq,
   output logic [15:0] rsp_rtp_next_seq,
   output logic [31:0] rsp_stream_ssrc,
   output logic [31:0] rsp_counter_value,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
   localparam logic [7:0] LAST_POS = 8'(PACKET_BYTES - 1);
   localparam logic [12:0] LAST_SLOT = 13'(tspc_pkg::PID_SLOTS - 1);

   logic [12:0] mark_pid_ff;
   logic [7:0]  marker_tid_ff;
   logic [11:0] marker_len_ff;

   logic [7:0]  pos_ff;
   logic        in_packet_ff;
   logic [7:0]  hdr_ff [tspc_pkg::HDR_KEEP];

   logic        clearing_ff;
   logic [12:0] clr_addr_ff;

   logic               s1_valid_ff;
   tspc_pkg::kind_type s1_kind_ff;
   logic [12:0]        s1_idx_ff;

   logic                  last_wr_valid_ff;
   logic [12:0]           last_wr_addr_ff;
   logic [COUNT_BITS-1:0] last_wr_data_ff;

   logic [COUNT_BITS-1:0] total_ff, sync_ff, marker_ff, null_ff, content_ff, pcr_ff;

   tspc_pkg::rsp_type q_ff [2];
   logic              q_wr_ptr_ff;
   logic              q_rd_ptr_ff;
   logic [1:0]        q_count_ff;
   logic [1:0]        q_count_in;

   logic        accept, byte_beat, open, last, push, pop;
   logic [7:0]  pos_eff;
   logic        s1_valid_in;
   tspc_pkg::kind_type s1_kind_in;
   logic [12:0] rd_addr;

   logic                  ram_we;
   logic [12:0]           ram_waddr;
   logic [COUNT_BITS-1:0] ram_wdata, ram_rdata, pid_count, sum_value;

   tspc_pkg::rsp_type rsp_now;
   tspc_pkg::upd_type upd;

   assign accept    = req_valid && req_ready;
   assign byte_beat = accept && req_action == tspc_pkg::ACT_BYTE;
   assign open      = req_packet_start || in_packet_ff;
   assign pos_eff   = req_packet_start ? 8'd0 : pos_ff;
   assign last      = pos_eff >= LAST_POS;
   assign rd_addr   = (req_action == tspc_pkg::ACT_PID_READ) ? req_counter_index
                                                             : {hdr_ff[1][4:0], hdr_ff[2]};

   always_comb begin
      s1_valid_in = 1'b0;
      s1_kind_in  = tspc_pkg::KIND_REPORT;
      if (accept) begin
         case (req_action)
            tspc_pkg::ACT_PID_READ: begin
               s1_valid_in = 1'b1;
               s1_kind_in  = tspc_pkg::KIND_PID_READ;
            end
            tspc_pkg::ACT_SUM_READ: begin
               s1_valid_in = 1'b1;
               s1_kind_in  = tspc_pkg::KIND_SUM_READ;
            end
            tspc_pkg::ACT_BYTE: begin
               s1_valid_in = open && last;
            end
            default: begin
               s1_valid_in = 1'b0;
            end
         endcase
      end
   end

   assign push       = s1_valid_ff;
   assign pop        = rsp_valid && rsp_ready;
   assign q_count_in = q_count_ff + {1'b0, push} - {1'b0, pop};
   assign req_ready  = !clearing_ff && q_count_in < 2'd2;

   assign pid_count = (last_wr_valid_ff && last_wr_addr_ff == s1_idx_ff) ? last_wr_data_ff
                                                                        : ram_rdata;

   always_comb begin
      case (s1_idx_ff)
         tspc_pkg::SUM_TOTAL:   sum_value = total_ff;
         tspc_pkg::SUM_SYNC:    sum_value = sync_ff;
         tspc_pkg::SUM_MARKER:  sum_value = marker_ff;
         tspc_pkg::SUM_NULL:    sum_value = null_ff;
         tspc_pkg::SUM_CONTENT: sum_value = content_ff;
         tspc_pkg::SUM_PCR:     sum_value = pcr_ff;
         default:               sum_value = '0;
      endcase
   end

   tspc_report #(.COUNT_BITS(COUNT_BITS)) u_report (
      .kind       (s1_kind_ff),
      .index      (s1_idx_ff),
      .hdr        (hdr_ff),
      .mark_pid   (mark_pid_ff),
      .marker_tid (marker_tid_ff),
      .marker_len (marker_len_ff),
      .pid_count  (pid_count),
      .sum_value  (sum_value),
      .rsp        (rsp_now),
      .upd        (upd)
   );

   assign ram_we    = clearing_ff || (s1_valid_ff && upd.cnt_we);
   assign ram_waddr = clearing_ff ? clr_addr_ff : s1_idx_ff;
   assign ram_wdata = clearing_ff ? '0 : pid_count + COUNT_BITS'(1);

   tspc_ram #(.WIDTH(COUNT_BITS), .DEPTH(tspc_pkg::PID_SLOTS)) u_count_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_pid_ff      <= tspc_pkg::MARKER_PID_RST;
         marker_tid_ff    <= tspc_pkg::MARKER_TID_RST;
         marker_len_ff    <= tspc_pkg::MARKER_LEN_RST;
         pos_ff           <= 8'd0;
         in_packet_ff     <= 1'b0;
         clearing_ff      <= 1'b1;
         clr_addr_ff      <= 13'd0;
         s1_valid_ff      <= 1'b0;
         last_wr_valid_ff <= 1'b0;
         total_ff         <= '0;
         sync_ff          <= '0;
         marker_ff        <= '0;
         null_ff          <= '0;
         content_ff       <= '0;
         pcr_ff           <= '0;
         q_wr_ptr_ff      <= 1'b0;
         q_rd_ptr_ff      <= 1'b0;
         q_count_ff       <= 2'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tspc_pkg::REG_MARKER_PID: mark_pid_ff <= csr_data;
               tspc_pkg::REG_MARKER_TID: marker_tid_ff <= csr_data[7:0];
               tspc_pkg::REG_MARKER_LEN: marker_len_ff <= csr_data[11:0];
               default: begin
               end
            endcase
         end
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 13'd1;
            if (clr_addr_ff == LAST_SLOT) begin
               clearing_ff <= 1'b0;
            end
         end
         if (byte_beat && open) begin
            if (last) begin
               in_packet_ff <= 1'b0;
               pos_ff       <= 8'd0;
            end else begin
               in_packet_ff <= 1'b1;
               pos_ff       <= pos_eff + 8'd1;
            end
         end
         s1_valid_ff      <= s1_valid_in;
         last_wr_valid_ff <= ram_we;
         if (s1_valid_ff) begin
            if (upd.total)    total_ff   <= total_ff + COUNT_BITS'(1);
            if (upd.sync_err) sync_ff    <= sync_ff + COUNT_BITS'(1);
            if (upd.marker)   marker_ff  <= marker_ff + COUNT_BITS'(1);
            if (upd.null_pkt) null_ff    <= null_ff + COUNT_BITS'(1);
            if (upd.content)  content_ff <= content_ff + COUNT_BITS'(1);
            if (upd.pcr)      pcr_ff     <= pcr_ff + COUNT_BITS'(1);
         end
         if (push) begin
            q_wr_ptr_ff <= !q_wr_ptr_ff;
         end
         if (pop) begin
            q_rd_ptr_ff <= !q_rd_ptr_ff;
         end
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_beat && open && pos_eff < 8'(tspc_pkg::HDR_KEEP)) begin
         hdr_ff[pos_eff[tspc_pkg::HDR_IDX_BITS-1:0]] <= req_byte_value;
      end
      if (accept) begin
         s1_kind_ff <= s1_kind_in;
         s1_idx_ff  <= (req_action == tspc_pkg::ACT_BYTE) ? rd_addr : req_counter_index;
      end
      last_wr_addr_ff <= ram_waddr;
      last_wr_data_ff <= ram_wdata;
      if (push) begin
         q_ff[q_wr_ptr_ff] <= rsp_now;
      end
   end

   assign rsp_valid           = q_count_ff != 2'd0;
   assign rsp_packet_class    = q_ff[q_rd_ptr_ff].packet_class;
   assign rsp_packet_pid      = q_ff[q_rd_ptr_ff].packet_pid;
   assign rsp_pcr_found       = q_ff[q_rd_ptr_ff].pcr_found;
   assign rsp_pcr_value       = q_ff[q_rd_ptr_ff].pcr_value;
   assign rsp_marker_status   = q_ff[q_rd_ptr_ff].marker_status;
   assign rsp_marker_sequence = q_ff[q_rd_ptr_ff].marker_sequence;
   assign rsp_marker_non_null = q_ff[q_rd_ptr_ff].marker_non_null;
   assign rsp_marker_null     = q_ff[q_rd_ptr_ff].marker_null;
   assign rsp_rtp_start_seq   = q_ff[q_rd_ptr_ff].rtp_start_seq;
   assign rsp_rtp_next_seq    = q_ff[q_rd_ptr_ff].rtp_next_seq;
   assign rsp_stream_ssrc     = q_ff[q_rd_ptr_ff].stream_ssrc;
   assign rsp_counter_value   = q_ff[q_rd_ptr_ff].counter_value;

   `TSPC_ASSERT(a_no_accept_clearing, clock, reset, clearing_ff |-> !req_ready)
   `TSPC_NEVER(a_queue_overflow, clock, reset, q_count_ff > 2'd2)
   `TSPC_ASSERT(a_stage_has_slot, clock, reset, s1_valid_ff |-> q_count_ff < 2'd2)
   `TSPC_ASSERT(a_push_after_accept, clock, reset, s1_valid_ff |-> $past(accept))
endmodule

// ===== tb/sv/ts_classifier_checker.sv =====
// checker for the transport stream packet classifier: watches request, result and csr ports
// keeps its own packet capture, counters and marker setup; depends on tspc_pkg
`timescale 1ns / 1ps
module ts_classifier_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_byte_value,
   input  logic        req_packet_start,
   input  logic [12:0] req_counter_index,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_packet_class,
   input  logic [12:0] rsp_packet_pid,
   input  logic        rsp_pcr_found,
   input  logic [41:0] rsp_pcr_value,
   input  logic [1:0]  rsp_marker_status,
   input  logic [31:0] rsp_marker_sequence,
   input  logic [15:0] rsp_marker_non_null,
   input  logic [15:0] rsp_marker_null,
   input  logic [15:0] rsp_rtp_start_seq,
   input  logic [15:0] rsp_rtp_next_seq,
   input  logic [31:0] rsp_stream_ssrc,
   input  logic [31:0] rsp_counter_value,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data,
   output int          fail_count,
   output int          pending
);
   logic [12:0] cfg_pid;
   logic [7:0]  cfg_tid;
   logic [11:0] cfg_len;
   logic [7:0]  pos;
   logic        open_pkt;
   logic [7:0]  hdr [tspc_pkg::HDR_KEEP];
   logic [31:0] pid_tally [tspc_pkg::PID_SLOTS];
   logic [31:0] cnt_total, cnt_sync, cnt_marker, cnt_null, cnt_content, cnt_pcr;
   tspc_pkg::rsp_type expected_q [$];

   function automatic logic [15:0] be16(int at);
      return {hdr[at], hdr[at+1]};
   endfunction

   function automatic logic [31:0] be32(int at);
      return {be16(at), be16(at+2)};
   endfunction

   task automatic classify_packet(output tspc_pkg::rsp_type r);
      logic [12:0] pid;
      logic [1:0]  afc;
      logic [63:0] base;
      logic [63:0] ext;
      r = '0;
      cnt_total++;
      if (hdr[0] != tspc_pkg::SYNC_BYTE) begin
         cnt_sync++;
         r.packet_class = tspc_pkg::CLS_SYNC_ERR;
         return;
      end
      pid = {hdr[1][4:0], hdr[2]};
      r.packet_pid = pid;
      pid_tally[pid]++;
      if (pid == tspc_pkg::NULL_PID) begin
         cnt_null++;
         r.packet_class = tspc_pkg::CLS_NULL;
      end else if (pid == cfg_pid) begin
         cnt_marker++;
         r.packet_class = tspc_pkg::CLS_MARKER;
         if (hdr[1][6] && hdr[4] == 8'd0) begin
            if (hdr[5] == cfg_tid && {hdr[6][3:0], hdr[7]} == cfg_len) begin
               r.marker_status   = tspc_pkg::MST_VALID;
               r.marker_sequence = be32(8);
               r.marker_non_null = be16(12);
               r.marker_null     = be16(14);
               r.rtp_start_seq   = be16(18);
               r.rtp_next_seq    = be16(22);
               r.stream_ssrc     = be32(24);
            end else begin
               r.marker_status = tspc_pkg::MST_INVALID;
            end
         end
      end else if (pid == tspc_pkg::PAT_PID) begin
         r.packet_class = tspc_pkg::CLS_PAT;
      end else if (pid == tspc_pkg::CAT_PID) begin
         r.packet_class = tspc_pkg::CLS_CAT;
      end else begin
         afc = hdr[3][5:4];
         if (afc[1] && hdr[4] >= tspc_pkg::PCR_MIN_AF_LEN && hdr[5][4]) begin
            base = {31'd0, hdr[6], hdr[7], hdr[8], hdr[9], hdr[10][7]};
            ext  = {55'd0, hdr[10][0], hdr[11]};
            cnt_pcr++;
            r.pcr_found = 1'b1;
            r.pcr_value = 42'(base * 300 + ext);
         end
         if (pid >= tspc_pkg::CONTENT_LO && pid <= tspc_pkg::CONTENT_HI) begin
            cnt_content++;
            r.packet_class = tspc_pkg::CLS_CONTENT;
         end else begin
            r.packet_class = tspc_pkg::CLS_RESERVED;
         end
      end
   endtask

   task automatic predict_beat();
      tspc_pkg::rsp_type r;
      r = '0;
      if (req_action == tspc_pkg::ACT_PID_READ || req_action == tspc_pkg::ACT_SUM_READ) begin
         r.packet_class = tspc_pkg::CLS_COUNTER;
         r.packet_pid   = req_counter_index;
         if (req_action == tspc_pkg::ACT_PID_READ) begin
            r.counter_value = pid_tally[req_counter_index];
         end else begin
            case (req_counter_index)
               tspc_pkg::SUM_TOTAL:   r.counter_value = cnt_total;
               tspc_pkg::SUM_SYNC:    r.counter_value = cnt_sync;
               tspc_pkg::SUM_MARKER:  r.counter_value = cnt_marker;
               tspc_pkg::SUM_NULL:    r.counter_value = cnt_null;
               tspc_pkg::SUM_CONTENT: r.counter_value = cnt_content;
               tspc_pkg::SUM_PCR:     r.counter_value = cnt_pcr;
               default:               r.counter_value = '0;
            endcase
         end
         expected_q.push_back(r);
         return;
      end
      if (req_action != tspc_pkg::ACT_BYTE) return;
      if (req_packet_start) begin
         open_pkt = 1'b1;
         pos = 8'd0;
      end else if (!open_pkt) begin
         return;
      end
      if (pos < tspc_pkg::HDR_KEEP) hdr[pos] = req_byte_value;
      if (pos >= tspc_pkg::PACKET_BYTES_DEF - 1) begin
         open_pkt = 1'b0;
         pos = 8'd0;
         classify_packet(r);
         expected_q.push_back(r);
      end else begin
         pos = pos + 8'd1;
      end
   endtask

   task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp, act);
         fail_count++;
      end
   endtask

   task automatic check_result();
      tspc_pkg::rsp_type e;
      if (expected_q.size() == 0) begin
         $error("result beat with nothing expected");
         fail_count++;
         return;
      end
      e = expected_q.pop_front();
      check_field("packet_class", e.packet_class, rsp_packet_class);
      check_field("packet_pid", e.packet_pid, rsp_packet_pid);
      check_field("pcr_found", e.pcr_found, rsp_pcr_found);
      check_field("pcr_value", e.pcr_value, rsp_pcr_value);
      check_field("marker_status", e.marker_status, rsp_marker_status);
      check_field("marker_sequence", e.marker_sequence, rsp_marker_sequence);
      check_field("marker_non_null", e.marker_non_null, rsp_marker_non_null);
      check_field("marker_null", e.marker_null, rsp_marker_null);
      check_field("rtp_start_seq", e.rtp_start_seq, rsp_rtp_start_seq);
      check_field("rtp_next_seq", e.rtp_next_seq, rsp_rtp_next_seq);
      check_field("stream_ssrc", e.stream_ssrc, rsp_stream_ssrc);
      check_field("counter_value", e.counter_value, rsp_counter_value);
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         cfg_pid = tspc_pkg::MARKER_PID_RST;
         cfg_tid = tspc_pkg::MARKER_TID_RST;
         cfg_len = tspc_pkg::MARKER_LEN_RST;
         pos = 8'd0;
         open_pkt = 1'b0;
         for (int i = 0; i < tspc_pkg::HDR_KEEP; i++) hdr[i] = 8'd0;
         for (int i = 0; i < tspc_pkg::PID_SLOTS; i++) pid_tally[i] = '0;
         cnt_total = '0; cnt_sync = '0; cnt_marker = '0;
         cnt_null = '0; cnt_content = '0; cnt_pcr = '0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               tspc_pkg::REG_MARKER_PID: cfg_pid = csr_data;
               tspc_pkg::REG_MARKER_TID: cfg_tid = csr_data[7:0];
               tspc_pkg::REG_MARKER_LEN: cfg_len = csr_data[11:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready) predict_beat();
      end
      pending = expected_q.size();
   end
endmodule

// ===== tb/sv/tb_ts_packet_classifier.sv =====
// top of the transport stream packet classifier testbench: clock, reset, stimulus, verdict
// depends on tspc_pkg, ts_packet_classifier and ts_classifier_checker
`timescale 1ns / 1ps
module tb_ts_packet_classifier;
   localparam int STALL_LIMIT = 40000;

   logic        clock;
   logic        reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_action;
   logic [7:0]  req_byte_value;
   logic        req_packet_start;
   logic [12:0] req_counter_index;
   logic        rsp_valid, rsp_ready;
   logic [2:0]  rsp_packet_class;
   logic [12:0] rsp_packet_pid;
   logic        rsp_pcr_found;
   logic [41:0] rsp_pcr_value;
   logic [1:0]  rsp_marker_status;
   logic [31:0] rsp_marker_sequence;
   logic [15:0] rsp_marker_non_null, rsp_marker_null;
   logic [15:0] rsp_rtp_start_seq, rsp_rtp_next_seq;
   logic [31:0] rsp_stream_ssrc, rsp_counter_value;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [12:0] csr_data;
   int          fail_count, pending;

   logic [12:0] cur_pid;
   logic [7:0]  cur_tid;
   logic [11:0] cur_len;
   bit          quiet;
   bit          hold_req;
   int          stall_cycles;

   ts_packet_classifier dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_byte_value(req_byte_value),
      .req_packet_start(req_packet_start), .req_counter_index(req_counter_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_packet_class(rsp_packet_class), .rsp_packet_pid(rsp_packet_pid),
      .rsp_pcr_found(rsp_pcr_found), .rsp_pcr_value(rsp_pcr_value),
      .rsp_marker_status(rsp_marker_status), .rsp_marker_sequence(rsp_marker_sequence),
      .rsp_marker_non_null(rsp_marker_non_null), .rsp_marker_null(rsp_marker_null),
      .rsp_rtp_start_seq(rsp_rtp_start_seq), .rsp_rtp_next_seq(rsp_rtp_next_seq),
      .rsp_stream_ssrc(rsp_stream_ssrc), .rsp_counter_value(rsp_counter_value),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   ts_classifier_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_byte_value(req_byte_value),
      .req_packet_start(req_packet_start), .req_counter_index(req_counter_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_packet_class(rsp_packet_class), .rsp_packet_pid(rsp_packet_pid),
      .rsp_pcr_found(rsp_pcr_found), .rsp_pcr_value(rsp_pcr_value),
      .rsp_marker_status(rsp_marker_status), .rsp_marker_sequence(rsp_marker_sequence),
      .rsp_marker_non_null(rsp_marker_non_null), .rsp_marker_null(rsp_marker_null),
      .rsp_rtp_start_seq(rsp_rtp_start_seq), .rsp_rtp_next_seq(rsp_rtp_next_seq),
      .rsp_stream_ssrc(rsp_stream_ssrc), .rsp_counter_value(rsp_counter_value),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_beat(logic [1:0] act, logic [7:0] b, logic start, logic [12:0] idx);
      logic rdy;
      while (!quiet && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_byte_value    <= b;
      req_packet_start  <= start;
      req_counter_index <= idx;
      do begin
         @(negedge clock);
         rdy = req_ready;
         @(posedge clock);
      end while (!rdy);
   endtask

   task automatic send_read();
      int r;
      r = int'($urandom_range(0, 9));
      if (r < 4) begin
         send_beat(tspc_pkg::ACT_PID_READ, 8'($urandom), 1'($urandom), 13'($urandom));
      end else if (r < 8) begin
         send_beat(tspc_pkg::ACT_SUM_READ, 8'($urandom), 1'($urandom),
                   13'($urandom_range(0, 7)));
      end else if (r < 9) begin
         send_beat(tspc_pkg::ACT_SUM_READ, 8'($urandom), 1'($urandom), 13'($urandom));
      end else begin
         send_beat(tspc_pkg::ACT_UNUSED, 8'($urandom), 1'($urandom), 13'($urandom));
      end
   endtask

   // builds and sends one packet; unless all ones, shaped so that markers and pcr fields are mostly well formed
   task automatic send_packet(logic [12:0] pid, bit truncate, bit reads, bit all_ones);
      logic [7:0] pkt [tspc_pkg::PACKET_BYTES_DEF];
      int n;
      for (int i = 0; i < tspc_pkg::PACKET_BYTES_DEF; i++) begin
         pkt[i] = all_ones ? 8'hFF : 8'($urandom);
      end
      pkt[0] = ($urandom_range(0, 19) == 0) ? 8'($urandom) : tspc_pkg::SYNC_BYTE;
      pkt[1] = {pkt[1][7:5], pid[12:8]};
      pkt[2] = pid[7:0];
      if (!all_ones) begin
         if ($urandom_range(0, 4) != 0) pkt[3][5] = 1'b1;
         if (pid == cur_pid && $urandom_range(0, 4) != 0) begin
            pkt[1][6] = 1'b1;
            pkt[4] = 8'd0;
            if ($urandom_range(0, 3) != 0) pkt[5] = cur_tid;
            if ($urandom_range(0, 3) != 0) pkt[6] = {pkt[6][7:4], cur_len[11:8]};
            if ($urandom_range(0, 3) != 0) pkt[7] = cur_len[7:0];
         end else if ($urandom_range(0, 4) != 0) begin
            pkt[4] = 8'($urandom_range(7, 183));
            pkt[5][4] = 1'b1;
         end
      end
      n = truncate ? int'($urandom_range(1, tspc_pkg::PACKET_BYTES_DEF - 1))
                   : tspc_pkg::PACKET_BYTES_DEF;
      for (int i = 0; i < n; i++) begin
         if (reads && $urandom_range(0, 29) == 0) send_read();
         send_beat(tspc_pkg::ACT_BYTE, pkt[i], i == 0, 13'($urandom));
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [12:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_marker(logic [12:0] pid, logic [7:0] tid, logic [11:0] len);
      settle();
      cur_pid = pid;
      cur_tid = tid;
      cur_len = len;
      write_reg(tspc_pkg::REG_MARKER_PID, pid);
      write_reg(tspc_pkg::REG_MARKER_TID, {5'd0, tid});
      write_reg(tspc_pkg::REG_MARKER_LEN, {1'b0, len});
   endtask

   // result side: random stalls unless quiet, plus one long hold-off when asked
   initial begin
      rsp_ready = 1'b0;
      stall_cycles = 0;
      forever begin
         @(posedge clock);
         if (hold_req && stall_cycles == 0) begin
            hold_req = 1'b0;
            stall_cycles = 600;
         end
         if (stall_cycles > 0) begin
            stall_cycles--;
            rsp_ready <= 1'b0;
         end else if (quiet) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 33);
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
         if (idle >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = tspc_pkg::ACT_BYTE;
      req_byte_value = 8'd0;
      req_packet_start = 1'b0;
      req_counter_index = 13'd0;
      csr_we = 1'b0;
      csr_index = tspc_pkg::REG_MARKER_PID;
      csr_data = 13'd0;
      quiet = 1'b0;
      hold_req = 1'b0;
      cur_pid = tspc_pkg::MARKER_PID_RST;
      cur_tid = tspc_pkg::MARKER_TID_RST;
      cur_len = tspc_pkg::MARKER_LEN_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reads on a fresh store, stray and unknown beats, one packet per pid class, a truncated packet
      for (int i = 0; i < 7; i++) send_beat(tspc_pkg::ACT_SUM_READ, 8'd0, 1'b0, 13'(i));
      send_beat(tspc_pkg::ACT_SUM_READ, 8'hFF, 1'b1, 13'h1FFF);
      send_beat(tspc_pkg::ACT_PID_READ, 8'd0, 1'b0, 13'd0);
      send_beat(tspc_pkg::ACT_PID_READ, 8'd0, 1'b0, 13'h1FFF);
      send_beat(tspc_pkg::ACT_UNUSED, 8'hFF, 1'b1, 13'h1FFF);
      send_beat(tspc_pkg::ACT_BYTE, 8'h47, 1'b0, 13'd0);
      send_packet(tspc_pkg::NULL_PID, 1'b0, 1'b0, 1'b0);
      send_packet(cur_pid, 1'b0, 1'b1, 1'b0);
      send_packet(tspc_pkg::PAT_PID, 1'b0, 1'b0, 1'b0);
      send_packet(tspc_pkg::CAT_PID, 1'b0, 1'b0, 1'b0);
      send_packet(13'h0002, 1'b0, 1'b0, 1'b0);
      send_packet(tspc_pkg::CONTENT_LO, 1'b0, 1'b0, 1'b1);
      send_packet(tspc_pkg::CONTENT_HI, 1'b1, 1'b0, 1'b0);
      send_beat(tspc_pkg::ACT_PID_READ, 8'd0, 1'b0, tspc_pkg::CONTENT_LO);
      send_beat(tspc_pkg::ACT_PID_READ, 8'd0, 1'b0, tspc_pkg::NULL_PID);

      // marker on the pat pid
      set_marker(13'd0, 8'd0, 12'd0);
      send_packet(tspc_pkg::PAT_PID, 1'b0, 1'b1, 1'b0);

      // long result hold-off while reads keep coming
      quiet = 1'b1;
      hold_req = 1'b1;
      for (int i = 0; i < 30; i++) send_read();

      // marker on the null pid, sent with no idling
      set_marker(13'h1FFF, 8'hFF, 12'hFFF);
      send_packet(tspc_pkg::NULL_PID, 1'b0, 1'b1, 1'b0);
      quiet = 1'b0;
      for (int i = 0; i < 6; i++) send_beat(tspc_pkg::ACT_SUM_READ, 8'd0, 1'b0, 13'(i));

      settle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
